FILE: design/ipmbrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPMB request parser package
// Shared item types and header layout constants.
// ----------------------------------------------------------------------------
package ipmbrp_pkg;

  // Header layout: netFn/rsLUN, checksum, rqSA, seq/rqLUN, cmd
  localparam int HDR_LEN   = 5;
  localparam int MIN_FRAME = 6;

  localparam logic [7:0] BCAST_MARK = 8'h00;
  localparam logic [7:0] POS_SAT    = 8'hFF;

  // Header byte positions, broadcast mark excluded
  localparam logic [7:0] POS_NETFN = 8'd0;
  localparam logic [7:0] POS_RQSA  = 8'd2;
  localparam logic [7:0] POS_SEQ   = 8'd3;
  localparam logic [7:0] POS_CMD   = 8'd4;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_summary;
    logic [7:0] data_byte;
    logic [4:0] data_index;
    logic       frame_ok;
    logic       is_broadcast;
    logic [5:0] net_function;
    logic [1:0] responder_lun;
    logic [7:0] requester_address;
    logic [5:0] sequence_number;
    logic [1:0] requester_lun;
    logic [7:0] command_code;
    logic [5:0] payload_length;
  } result_t;

endpackage
`default_nettype wire

FILE: design/ipmbrp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPMB request parser input stage
// Registers one byte transfer and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module ipmbrp_in_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  ipmbrp_pkg::in_item_t in_item,
  input  wire                  advance,
  output logic                 q_valid,
  output ipmbrp_pkg::in_item_t q_item
);
  import ipmbrp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // stall only while a held byte cannot move on
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule
`default_nettype wire

FILE: design/ipmbrp_frame_state.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPMB request parser frame state
// Tracks byte position, checksums and header fields; forms each result.
// ----------------------------------------------------------------------------
module ipmbrp_frame_state #(
  parameter int MAX_DATA = 32
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  fire,
  input  ipmbrp_pkg::in_item_t item,
  input  wire [7:0]            local_address,
  output logic                 res_valid,
  output ipmbrp_pkg::result_t  res
);
  import ipmbrp_pkg::*;

  localparam logic [7:0] HDR_END  = 8'(HDR_LEN);
  localparam logic [7:0] MAX8     = 8'(MAX_DATA);
  localparam logic [7:0] DATA_END = 8'(MAX_DATA + HDR_LEN);

  logic [7:0] pos_r, pos_nxt;
  logic       bc_r, bc_nxt;
  logic [7:0] hsum_r, hsum_nxt;
  logic [7:0] bsum_r, bsum_nxt;
  logic [5:0] netfn_r, netfn_nxt;
  logic [1:0] rslun_r, rslun_nxt;
  logic [7:0] rqsa_r, rqsa_nxt;
  logic [5:0] seq_r, seq_nxt;
  logic [1:0] rqlun_r, rqlun_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic       ovf_r, ovf_nxt;

  logic       mark;
  logic       long_enough;
  logic [7:0] plen_full;
  logic       plen_over;
  logic [7:0] plen;
  logic [7:0] hdr_check;
  logic       hdr_ok;
  logic       body_ok;
  logic       produce;
  result_t    res_c;

  always_comb begin
    pos_nxt   = pos_r;
    bc_nxt    = bc_r;
    hsum_nxt  = hsum_r;
    bsum_nxt  = bsum_r;
    netfn_nxt = netfn_r;
    rslun_nxt = rslun_r;
    rqsa_nxt  = rqsa_r;
    seq_nxt   = seq_r;
    rqlun_nxt = rqlun_r;
    cmd_nxt   = cmd_r;
    ovf_nxt   = ovf_r;
    produce   = 1'b0;
    res_c     = '0;

    mark        = (pos_r == 8'd0) && !bc_r && (item.rx_byte == BCAST_MARK);
    long_enough = pos_r >= HDR_END;
    plen_full   = pos_r - HDR_END;
    plen_over   = plen_full > MAX8;
    plen        = !long_enough ? 8'd0 : (plen_over ? MAX8 : plen_full);
    hdr_check   = 8'd0;
    hdr_ok      = 1'b0;
    body_ok     = 1'b0;

    if (mark) begin
      // drop the broadcast mark; a lone mark is a failed empty frame
      bc_nxt = 1'b1;
      if (item.last_byte) begin
        produce            = 1'b1;
        res_c.is_summary   = 1'b1;
        res_c.is_broadcast = 1'b1;
        bc_nxt             = 1'b0;
      end
    end else begin
      case (pos_r)
        POS_NETFN: begin
          netfn_nxt = item.rx_byte[7:2];
          rslun_nxt = item.rx_byte[1:0];
        end
        POS_RQSA: rqsa_nxt = item.rx_byte;
        POS_SEQ: begin
          seq_nxt   = item.rx_byte[7:2];
          rqlun_nxt = item.rx_byte[1:0];
        end
        POS_CMD: cmd_nxt = item.rx_byte;
        default: ;
      endcase
      if (pos_r < POS_RQSA) begin
        hsum_nxt = hsum_r + item.rx_byte;
      end else begin
        bsum_nxt = bsum_r + item.rx_byte;
      end
      hdr_check = hsum_nxt + local_address;
      hdr_ok    = hdr_check == 8'd0;
      body_ok   = bsum_nxt == 8'd0;

      if (!item.last_byte) begin
        if (long_enough) begin
          if (pos_r >= DATA_END) begin
            ovf_nxt = 1'b1;
          end else begin
            produce          = 1'b1;
            res_c.data_byte  = item.rx_byte;
            res_c.data_index = plen_full[4:0];
          end
        end
        if (pos_r != POS_SAT) begin
          pos_nxt = pos_r + 8'd1;
        end
      end else begin
        produce                 = 1'b1;
        res_c.is_summary        = 1'b1;
        res_c.frame_ok          = long_enough && !ovf_r && !plen_over && hdr_ok && body_ok;
        res_c.is_broadcast      = bc_r;
        res_c.net_function      = netfn_nxt;
        res_c.responder_lun     = rslun_nxt;
        res_c.requester_address = rqsa_nxt;
        res_c.sequence_number   = seq_nxt;
        res_c.requester_lun     = rqlun_nxt;
        res_c.command_code      = cmd_nxt;
        res_c.payload_length    = plen[5:0];
        // start the next frame from a clean slate
        pos_nxt   = '0;
        bc_nxt    = 1'b0;
        hsum_nxt  = '0;
        bsum_nxt  = '0;
        netfn_nxt = '0;
        rslun_nxt = '0;
        rqsa_nxt  = '0;
        seq_nxt   = '0;
        rqlun_nxt = '0;
        cmd_nxt   = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      bc_r    <= 1'b0;
      hsum_r  <= '0;
      bsum_r  <= '0;
      netfn_r <= '0;
      rslun_r <= '0;
      rqsa_r  <= '0;
      seq_r   <= '0;
      rqlun_r <= '0;
      cmd_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      bc_r    <= bc_nxt;
      hsum_r  <= hsum_nxt;
      bsum_r  <= bsum_nxt;
      netfn_r <= netfn_nxt;
      rslun_r <= rslun_nxt;
      rqsa_r  <= rqsa_nxt;
      seq_r   <= seq_nxt;
      rqlun_r <= rqlun_nxt;
      cmd_r   <= cmd_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign res_valid = fire && produce;
  assign res       = res_c;

  a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.is_summary |=> pos_r == 8'd0 && !bc_r && hsum_r == 8'd0 && !ovf_r)
    else $error("frame state not cleared after summary");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.is_summary |-> pos_r >= HDR_END && pos_r < DATA_END)
    else $error("data result outside data window");

  a_ok_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.frame_ok |-> res.is_summary && long_enough && !ovf_r)
    else $error("good frame verdict on short or overflowed frame");

endmodule
`default_nettype wire

FILE: design/ipmbrp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPMB request parser output stage
// Result register; holds a result while the receiver stalls.
// ----------------------------------------------------------------------------
module ipmbrp_out_stage (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 load,
  input  ipmbrp_pkg::result_t res,
  output logic                advance,
  output logic                out_valid,
  input  wire                 out_stall,
  output ipmbrp_pkg::result_t out_res
);
  import ipmbrp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // free when empty or when the held result leaves this cycle
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

FILE: design/ipmb_request_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPMB request parser
// Splits a received IPMB request frame into header fields and data bytes
// and checks both frame checksums.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | rx_byte, last_byte
//  out_    | output    | out_valid/out_stall| data byte or end-of-frame summary
//  cfg_    | input     | cfg_we             | local_address
//
// One byte is taken every cycle while in_stall is low; the parser logic sits between the input
// register and the result register, so a byte is held in the input register and its result is
// loaded into the result register before it can transfer out.
// Header bytes and a leading broadcast mark give no result unless they end the frame, nor do dropped overflow bytes.
// Reset clears the frame state, both stage valids and local_address.
// out_stall holds the result register and, once the input register is full
// behind it, raises in_stall in the same cycle.
//
module ipmb_request_parser #(
  parameter int MAX_DATA = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  // configuration
  input  wire        cfg_we,
  input  wire  [7:0] cfg_wdata,
  // byte input
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  input  wire        in_last_byte,
  // results
  output logic       out_valid,
  input  wire        out_stall,
  output logic       out_is_summary,
  output logic [7:0] out_data_byte,
  output logic [4:0] out_data_index,
  output logic       out_frame_ok,
  output logic       out_is_broadcast,
  output logic [5:0] out_net_function,
  output logic [1:0] out_responder_lun,
  output logic [7:0] out_requester_address,
  output logic [5:0] out_sequence_number,
  output logic [1:0] out_requester_lun,
  output logic [7:0] out_command_code,
  output logic [5:0] out_payload_length
);
  import ipmbrp_pkg::*;

  logic [7:0] local_address_r;
  in_item_t   in_item;
  in_item_t   q_item;
  logic       q_valid;
  logic       advance;
  logic       fire;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // own address register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_address_r <= '0;
    end else if (cfg_we) begin
      local_address_r <= cfg_wdata;
    end
  end

  assign in_item.rx_byte   = in_rx_byte;
  assign in_item.last_byte = in_last_byte;

  ipmbrp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_item   (q_item)
  );

  // process the held byte whenever the result register can take its result
  assign fire = q_valid && advance;

  ipmbrp_frame_state #(
    .MAX_DATA (MAX_DATA)
  ) u_frame (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .item          (q_item),
    .local_address (local_address_r),
    .res_valid     (res_valid),
    .res           (res)
  );

  ipmbrp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_is_summary        = out_res.is_summary;
  assign out_data_byte         = out_res.data_byte;
  assign out_data_index        = out_res.data_index;
  assign out_frame_ok          = out_res.frame_ok;
  assign out_is_broadcast      = out_res.is_broadcast;
  assign out_net_function      = out_res.net_function;
  assign out_responder_lun     = out_res.responder_lun;
  assign out_requester_address = out_res.requester_address;
  assign out_sequence_number   = out_res.sequence_number;
  assign out_requester_lun     = out_res.requester_lun;
  assign out_command_code      = out_res.command_code;
  assign out_payload_length    = out_res.payload_length;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> q_valid && out_valid && out_stall)
    else $error("input stalled without a blocked result");

endmodule
`default_nettype wire

FILE: tb/ipmbrp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPMB request parser result checker
// Watches the byte, result and configuration ports of the parser, works out
// the result of every byte transfer and compares each result transfer with
// the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module ipmbrp_checker #(
  parameter int MAX_DATA = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_we,
  input  wire   [7:0] cfg_wdata,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire   [7:0] in_rx_byte,
  input  wire         in_last_byte,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire         out_is_summary,
  input  wire   [7:0] out_data_byte,
  input  wire   [4:0] out_data_index,
  input  wire         out_frame_ok,
  input  wire         out_is_broadcast,
  input  wire   [5:0] out_net_function,
  input  wire   [1:0] out_responder_lun,
  input  wire   [7:0] out_requester_address,
  input  wire   [5:0] out_sequence_number,
  input  wire   [1:0] out_requester_lun,
  input  wire   [7:0] out_command_code,
  input  wire   [5:0] out_payload_length,
  output int          fail_count,
  output int unsigned pending_count
);
  import ipmbrp_pkg::*;

  int          mismatches      = 0;
  int unsigned results_waiting = 0;
  int unsigned result_num      = 0;

  assign fail_count    = mismatches;
  assign pending_count = results_waiting;

  // Results still owed by the parser, oldest first
  result_t pending_results[$];

  // Own copy of the register and of the frame in progress
  logic [7:0] local_addr;
  logic [7:0] frame_pos;
  logic       bcast_seen;
  logic [7:0] hdr_sum;
  logic [7:0] body_sum;
  logic       overflow_seen;
  result_t    frame_hdr;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch on result %0d: %s", $time, result_num, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic compare_result(input result_t got, input result_t want);
    check_field("is_summary", got.is_summary, want.is_summary);
    check_field("data_byte", got.data_byte, want.data_byte);
    check_field("data_index", got.data_index, want.data_index);
    check_field("frame_ok", got.frame_ok, want.frame_ok);
    check_field("is_broadcast", got.is_broadcast, want.is_broadcast);
    check_field("net_function", got.net_function, want.net_function);
    check_field("responder_lun", got.responder_lun, want.responder_lun);
    check_field("requester_address", got.requester_address, want.requester_address);
    check_field("sequence_number", got.sequence_number, want.sequence_number);
    check_field("requester_lun", got.requester_lun, want.requester_lun);
    check_field("command_code", got.command_code, want.command_code);
    check_field("payload_length", got.payload_length, want.payload_length);
  endtask

  task automatic restart_frame();
    frame_pos     = '0;
    bcast_seen    = 1'b0;
    hdr_sum       = '0;
    body_sum      = '0;
    overflow_seen = 1'b0;
    frame_hdr     = '0;
  endtask

  // Parse one received byte and queue the result it causes, if any
  task automatic parse_rx_byte(input logic [7:0] b, input logic is_last);
    result_t     r;
    int unsigned pos_i;
    int unsigned idx;
    int unsigned plen;
    logic [7:0]  hdr_total;
    bit          long_enough;
    r     = '0;
    pos_i = frame_pos;
    if (pos_i == 0 && !bcast_seen && b == BCAST_MARK) begin
      bcast_seen = 1'b1;
      if (is_last) begin
        r.is_summary   = 1'b1;
        r.is_broadcast = 1'b1;
        pending_results.push_back(r);
        restart_frame();
      end
      return;
    end
    case (frame_pos)
      POS_NETFN: begin
        frame_hdr.net_function  = b[7:2];
        frame_hdr.responder_lun = b[1:0];
      end
      POS_RQSA: frame_hdr.requester_address = b;
      POS_SEQ: begin
        frame_hdr.sequence_number = b[7:2];
        frame_hdr.requester_lun   = b[1:0];
      end
      POS_CMD: frame_hdr.command_code = b;
      default: ;
    endcase
    if (pos_i < 2) hdr_sum = hdr_sum + b;
    else body_sum = body_sum + b;
    if (!is_last) begin
      if (pos_i >= HDR_LEN) begin
        idx = pos_i - HDR_LEN;
        if (idx >= MAX_DATA) begin
          overflow_seen = 1'b1;
        end else begin
          r.data_byte  = b;
          r.data_index = idx[4:0];
          pending_results.push_back(r);
        end
      end
      if (frame_pos != POS_SAT) frame_pos = frame_pos + 8'd1;
    end else begin
      long_enough = (pos_i + 1) >= MIN_FRAME;
      plen        = 0;
      if (long_enough) begin
        plen = pos_i + 1 - MIN_FRAME;
        if (plen > MAX_DATA) begin
          plen          = MAX_DATA;
          overflow_seen = 1'b1;
        end
      end
      hdr_total        = hdr_sum + local_addr;
      r                = frame_hdr;
      r.is_summary     = 1'b1;
      r.frame_ok       = long_enough && !overflow_seen && hdr_total == 8'h00 &&
                         body_sum == 8'h00;
      r.is_broadcast   = bcast_seen;
      r.payload_length = plen[5:0];
      pending_results.push_back(r);
      restart_frame();
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    if (!rst_n) begin
      pending_results.delete();
      local_addr = '0;
      restart_frame();
    end else begin
      if (cfg_we) local_addr = cfg_wdata;
      if (out_valid && !out_stall) begin
        got = {out_is_summary, out_data_byte, out_data_index, out_frame_ok,
               out_is_broadcast, out_net_function, out_responder_lun,
               out_requester_address, out_sequence_number, out_requester_lun,
               out_command_code, out_payload_length};
        result_num++;
        if (pending_results.size() == 0) report_mismatch("result with no expectation waiting");
        else compare_result(got, pending_results.pop_front());
      end
      if (in_valid && !in_stall) parse_rx_byte(in_rx_byte, in_last_byte);
    end
    results_waiting = pending_results.size();
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPMB request parser testbench
// Feeds directed and random request frames (good, corrupted, truncated,
// oversized and plain noise) through the parser under random sender gaps and
// receiver stalls, across several local addresses, and lets the checker
// judge every result.
// ----------------------------------------------------------------------------
module tb;
  import ipmbrp_pkg::*;

  localparam int          MAX_DATA       = 32;
  localparam int unsigned TARGET_ITEMS   = 800;
  localparam int unsigned PHASE_ITEMS    = 100;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned DRAIN_TAIL     = 4;     // two-stage pipeline plus margin
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       cfg_we       = 1'b0;
  logic [7:0] cfg_wdata    = '0;
  logic       in_valid     = 1'b0;
  logic [7:0] in_rx_byte   = '0;
  logic       in_last_byte = 1'b0;
  logic       out_stall    = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic       out_is_summary;
  logic [7:0] out_data_byte;
  logic [4:0] out_data_index;
  logic       out_frame_ok;
  logic       out_is_broadcast;
  logic [5:0] out_net_function;
  logic [1:0] out_responder_lun;
  logic [7:0] out_requester_address;
  logic [5:0] out_sequence_number;
  logic [1:0] out_requester_lun;
  logic [7:0] out_command_code;
  logic [5:0] out_payload_length;

  int          fail_count;
  int unsigned pending_count;

  bit          long_hold_req = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  int unsigned idle_cycles   = 0;
  logic [7:0]  cur_addr      = '0;
  logic [7:0]  tx_frame[$];

  always #6 clk = ~clk;

  ipmb_request_parser #(.MAX_DATA(MAX_DATA)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_is_summary       (out_is_summary),
    .out_data_byte        (out_data_byte),
    .out_data_index       (out_data_index),
    .out_frame_ok         (out_frame_ok),
    .out_is_broadcast     (out_is_broadcast),
    .out_net_function     (out_net_function),
    .out_responder_lun    (out_responder_lun),
    .out_requester_address(out_requester_address),
    .out_sequence_number  (out_sequence_number),
    .out_requester_lun    (out_requester_lun),
    .out_command_code     (out_command_code),
    .out_payload_length   (out_payload_length)
  );

  ipmbrp_checker #(.MAX_DATA(MAX_DATA)) result_check (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_rx_byte           (in_rx_byte),
    .in_last_byte         (in_last_byte),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_is_summary       (out_is_summary),
    .out_data_byte        (out_data_byte),
    .out_data_index       (out_data_index),
    .out_frame_ok         (out_frame_ok),
    .out_is_broadcast     (out_is_broadcast),
    .out_net_function     (out_net_function),
    .out_responder_lun    (out_responder_lun),
    .out_requester_address(out_requester_address),
    .out_sequence_number  (out_sequence_number),
    .out_requester_lun    (out_requester_lun),
    .out_command_code     (out_command_code),
    .out_payload_length   (out_payload_length),
    .fail_count           (fail_count),
    .pending_count        (pending_count)
  );

  // Offer one byte and hold it until the transfer. Open a new burst with a
  // random gap (often none) once the current burst is used up.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
    end
    in_valid     <= 1'b1;
    in_rx_byte   <= b;
    in_last_byte <= is_last;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // Send the first len bytes of the built frame, flagging the final one
  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(tx_frame[i], i == len - 1);
  endtask

  // Build a request frame for the current local address. Corrupt a checksum
  // by a nonzero offset on request; fill < 0 means random data.
  task automatic build_request(input bit bcast, input logic [7:0] hdr0,
                               input logic [7:0] rqsa, input logic [7:0] seqb,
                               input logic [7:0] cmd, input int ndata,
                               input int fill, input bit bad_hdr, input bit bad_body);
    logic [7:0] chk;
    logic [7:0] body;
    logic [7:0] d;
    tx_frame.delete();
    if (bcast) tx_frame.push_back(BCAST_MARK);
    tx_frame.push_back(hdr0);
    chk = 8'h00 - cur_addr - hdr0;
    if (bad_hdr) chk = chk + 8'($urandom_range(1, 255));
    tx_frame.push_back(chk);
    tx_frame.push_back(rqsa);
    tx_frame.push_back(seqb);
    tx_frame.push_back(cmd);
    body = rqsa + seqb + cmd;
    for (int i = 0; i < ndata; i++) begin
      d = (fill < 0) ? 8'($urandom) : 8'(fill);
      body = body + d;
      tx_frame.push_back(d);
    end
    chk = 8'h00 - body;
    if (bad_body) chk = chk + 8'($urandom_range(1, 255));
    tx_frame.push_back(chk);
  endtask

  // Drop valid and wait until every owed result has come, then let the
  // pipeline settle so that trailing header bytes are fully absorbed.
  task automatic wait_results_drained();
    in_valid  <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_local_address(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cur_addr   = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver: stall in windows of random density, some with no stall at all.
  // On request, hold off for a long stretch so the parser fills up and
  // pushes back on the sender.
  initial begin : receiver
    int unsigned window;
    int unsigned pct;
    int unsigned i;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        window = $urandom_range(16, 80);
        case ($urandom_range(3))
          0:       pct = 0;
          1:       pct = 20;
          2:       pct = 50;
          default: pct = 85;
        endcase
        for (i = 0; i < window && !long_hold_req; i++) begin
          out_stall <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog: end the run when nothing has transferred for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned phase_end;
    int          kind;
    int          sel;
    int          n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the address extremes
    set_local_address(8'h00);
    // lone zero byte: broadcast with nothing behind it
    send_byte(BCAST_MARK, 1'b1);
    // short frame whose final byte carries the requester address
    build_request(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, -1, 1'b0, 1'b0);
    send_frame(3);
    // minimal good broadcast request, all header fields at their top
    build_request(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, -1, 1'b0, 1'b0);
    send_frame(tx_frame.size());
    wait_results_drained();

    set_local_address(8'hFF);
    // good request with two all-ones data bytes and header fields zero but for rsLUN
    build_request(1'b0, 8'h01, 8'h00, 8'h00, 8'h00, 2, 8'hFF, 1'b0, 1'b0);
    send_frame(tx_frame.size());
    // header only, final byte is the command
    build_request(1'b0, 8'hFC, 8'h20, 8'h03, 8'h01, 0, -1, 1'b0, 1'b0);
    send_frame(5);

    // Random phases, each under its own local address
    for (ph = 0; items_sent < TARGET_ITEMS; ph++) begin
      wait_results_drained();
      case (ph % 4)
        0:       set_local_address(8'h20);
        1:       set_local_address(8'hFF);
        2:       set_local_address(8'h00);
        default: set_local_address(8'($urandom));
      endcase
      if (ph == 2) long_hold_req = 1'b1;
      // one very long frame to drive the byte position into saturation
      if (ph == 3) begin
        for (int i = 0; i < 300; i++) send_byte(8'($urandom), i == 299);
      end
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        kind = $urandom_range(99);
        if (kind < 62) begin
          // well-formed request, mostly short data, sometimes up to the limit
          build_request($urandom_range(4) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom),
                        ($urandom_range(9) == 0) ? $urandom_range(9, MAX_DATA)
                                                 : $urandom_range(0, 8),
                        -1, 1'b0, 1'b0);
          send_frame(tx_frame.size());
        end else if (kind < 72) begin
          // corrupt one checksum or both
          sel = $urandom_range(1, 3);
          build_request($urandom_range(4) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), $urandom_range(0, 6), -1, sel[0], sel[1]);
          send_frame(tx_frame.size());
        end else if (kind < 80) begin
          // truncated frame
          build_request($urandom_range(2) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), $urandom_range(0, 4), -1, 1'b0, 1'b0);
          send_frame($urandom_range(1, 6));
        end else if (kind < 86) begin
          // more data than the parser keeps
          build_request($urandom_range(4) == 0, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), $urandom_range(MAX_DATA + 1, MAX_DATA + 8), -1,
                        1'b0, 1'b0);
          send_frame(tx_frame.size());
        end else if (kind < 96) begin
          // noise: random bytes with random frame ends
          n = $urandom_range(1, 12);
          for (int j = 0; j < n; j++) begin
            send_byte(8'($urandom), j == n - 1 || $urandom_range(5) == 0);
          end
        end else begin
          send_byte(BCAST_MARK, 1'b1);
        end
      end
    end

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
